@@ src/handheld_console_memory_map_with_dma_macros.svh @@
// assertion macros for the memory bus block
`ifndef HANDHELD_CONSOLE_MEMORY_MAP_WITH_DMA_MACROS_SVH
`define HANDHELD_CONSOLE_MEMORY_MAP_WITH_DMA_MACROS_SVH
`ifndef SYNTHESIS
`define HCM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HCM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HCM_ASSERT(label, clk, rst_n, prop, msg)
`define HCM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ src/hcmm_pkg.sv @@
// ----------------------------------------------------------------------------
// hcmm_pkg
// types, constants and the boot image of the console memory bus
// ----------------------------------------------------------------------------
package hcmm_pkg;

    localparam int ROM_BYTES      = 32768;
    localparam int VIDEO_BYTES    = 8192;
    localparam int CART_RAM_BYTES = 8192;
    localparam int WORK_RAM_BYTES = 8192;
    localparam int SPRITE_BYTES   = 160;
    localparam int DMA_LENGTH     = 160;
    localparam int IO_BYTES       = 128;
    localparam int HIGH_BYTES     = 128;

    localparam logic [15:0] BOOT_END      = 16'h0100;
    localparam logic [15:0] SPRITE_BASE   = 16'hFE00;
    localparam logic [15:0] GAP_BASE      = 16'hFEA0;
    localparam logic [15:0] IO_BASE       = 16'hFF00;
    localparam logic [15:0] HIGH_BASE     = 16'hFF80;
    localparam logic [15:0] BOOT_OFF_ADDR = 16'hFF50;
    localparam logic [15:0] DMA_REG_ADDR  = 16'hFF46;

    typedef enum logic [2:0] {
        OP_READ_BYTE  = 3'd0,
        OP_WRITE_BYTE = 3'd1,
        OP_READ_WORD  = 3'd2,
        OP_WRITE_WORD = 3'd3,
        OP_DMA_TICK   = 3'd4,
        OP_ROM_LOAD   = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        DMA_IDLE = 2'd0,
        DMA_REQ  = 2'd1,
        DMA_XFER = 2'd2
    } dma_state_t;

    // controller to datapath
    typedef struct packed {
        logic        load;      // capture input item
        logic        access;    // perform one byte access this cycle
        logic        second;    // access targets the second byte
        logic        finish;    // result register load
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic        two_access;  // item needs a second access
    } dp_status_t;

    function automatic logic [7:0] boot_byte(input logic [7:0] a);
        logic [7:0] img [256];
        img = '{
        8'h31,8'hFE,8'hFF,8'hAF,8'h21,8'hFF,8'h9F,8'h32,8'hCB,8'h7C,8'h20,8'hFB,8'h21,8'h26,8'hFF,8'h0E,
        8'h11,8'h3E,8'h80,8'h32,8'hE2,8'h0C,8'h3E,8'hF3,8'hE2,8'h32,8'h3E,8'h77,8'h77,8'h3E,8'hFC,8'hE0,
        8'h47,8'h11,8'h04,8'h01,8'h21,8'h10,8'h80,8'h1A,8'hCD,8'h95,8'h00,8'hCD,8'h96,8'h00,8'h13,8'h7B,
        8'hFE,8'h34,8'h20,8'hF3,8'h11,8'hD8,8'h00,8'h06,8'h08,8'h1A,8'h13,8'h22,8'h23,8'h05,8'h20,8'hF9,
        8'h3E,8'h19,8'hEA,8'h10,8'h99,8'h21,8'h2F,8'h99,8'h0E,8'h0C,8'h3D,8'h28,8'h08,8'h32,8'h0D,8'h20,
        8'hF9,8'h2E,8'h0F,8'h18,8'hF3,8'h67,8'h3E,8'h64,8'h57,8'hE0,8'h42,8'h3E,8'h91,8'hE0,8'h40,8'h04,
        8'h1E,8'h02,8'h0E,8'h0C,8'hF0,8'h44,8'hFE,8'h90,8'h20,8'hFA,8'h0D,8'h20,8'hF7,8'h1D,8'h20,8'hF2,
        8'h0E,8'h13,8'h24,8'h7C,8'h1E,8'h83,8'hFE,8'h62,8'h28,8'h06,8'h1E,8'hC1,8'hFE,8'h64,8'h20,8'h06,
        8'h7B,8'hE2,8'h0C,8'h3E,8'h87,8'hF2,8'hF0,8'h42,8'h90,8'hE0,8'h42,8'h15,8'h20,8'hD2,8'h05,8'h20,
        8'h4F,8'h16,8'h20,8'h18,8'hCB,8'h4F,8'h06,8'h04,8'hC5,8'hCB,8'h11,8'h17,8'hC1,8'hCB,8'h11,8'h17,
        8'h05,8'h20,8'hF5,8'h22,8'h23,8'h22,8'h23,8'hC9,8'hCE,8'hED,8'h66,8'h66,8'hCC,8'h0D,8'h00,8'h0B,
        8'h03,8'h73,8'h00,8'h83,8'h00,8'h0C,8'h00,8'h0D,8'h00,8'h08,8'h11,8'h1F,8'h88,8'h89,8'h00,8'h0E,
        8'hDC,8'hCC,8'h6E,8'hE6,8'hDD,8'hDD,8'hD9,8'h99,8'hBB,8'hBB,8'h67,8'h63,8'h6E,8'h0E,8'hEC,8'hCC,
        8'hDD,8'hDC,8'h99,8'h9F,8'hBB,8'hB9,8'h33,8'h3E,8'h3C,8'h42,8'hB9,8'hA5,8'hB9,8'hA5,8'h42,8'h3C,
        8'h21,8'h04,8'h01,8'h11,8'hA8,8'h00,8'h1A,8'h13,8'hBE,8'h20,8'hFE,8'h23,8'h7D,8'hFE,8'h34,8'h20,
        8'hF5,8'h06,8'h19,8'h78,8'h86,8'h23,8'h05,8'h20,8'hFB,8'h86,8'h20,8'hFE,8'h3E,8'h01,8'hE0,8'h50
        };
        return img[a];
    endfunction

endpackage

@@ src/hcmm_bus_if.sv @@
// ----------------------------------------------------------------------------
// hcmm_bus_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface hcmm_bus_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ src/hcmm_ctrl.sv @@
// ----------------------------------------------------------------------------
// hcmm_ctrl
// sequencer: capture, one or two byte accesses, result hand-off
// ----------------------------------------------------------------------------
`include "handheld_console_memory_map_with_dma_macros.svh"
module hcmm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  hcmm_pkg::dp_status_t  status,
    output hcmm_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FIRST  = 4'b0010,
        ST_SECOND = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   res_free;

    // result slot free when empty or being taken this cycle
    assign res_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                cmd.access = 1'b1;
                if (status.two_access)
                    state_next = ST_SECOND;
                else
                    state_next = ST_DONE;
            end
            ST_SECOND:
            begin
                cmd.access = 1'b1;
                cmd.second = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // read data of the last access is registered by now
                if (res_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `HCM_ASSERT(a_state_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
    `HCM_ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid_reg,
        "finished item not presented")
    `HCM_ASSERT(a_no_overwrite, clk, rst_n, !(cmd.finish && out_valid_reg && !out_ready),
        "result overwritten while stalled")

endmodule

@@ src/hcmm_datapath.sv @@
// ----------------------------------------------------------------------------
// hcmm_datapath
// address decode, region memories, boot overlay and sprite dma state
// ----------------------------------------------------------------------------
module hcmm_datapath #(
    parameter int DMA_LENGTH = hcmm_pkg::DMA_LENGTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hcmm_pkg::dp_cmd_t     cmd,
    output hcmm_pkg::dp_status_t  status,
    input  logic [2:0]            opcode,
    input  logic [15:0]           address,
    input  logic [15:0]           write_data,
    output logic [15:0]           read_data,
    output logic                  dma_active
);

    localparam int RA = $clog2(hcmm_pkg::ROM_BYTES);
    localparam int VA = $clog2(hcmm_pkg::VIDEO_BYTES);
    localparam int CA = $clog2(hcmm_pkg::CART_RAM_BYTES);
    localparam int WA = $clog2(hcmm_pkg::WORK_RAM_BYTES);
    localparam int SA = $clog2(hcmm_pkg::SPRITE_BYTES);
    localparam int IA = $clog2(hcmm_pkg::IO_BYTES);
    localparam int HA = $clog2(hcmm_pkg::HIGH_BYTES);

    typedef enum logic [3:0] {
        RG_BOOT   = 4'd0,
        RG_ROM    = 4'd1,
        RG_VIDEO  = 4'd2,
        RG_CRAM   = 4'd3,
        RG_WRAM   = 4'd4,
        RG_SPRITE = 4'd5,
        RG_GAP    = 4'd6,
        RG_IO     = 4'd7,
        RG_HIGH   = 4'd8
    } region_t;

    logic [7:0] rom_mem    [hcmm_pkg::ROM_BYTES];
    logic [7:0] video_mem  [hcmm_pkg::VIDEO_BYTES];
    logic [7:0] cram_mem   [hcmm_pkg::CART_RAM_BYTES];
    logic [7:0] wram_mem   [hcmm_pkg::WORK_RAM_BYTES];
    logic [7:0] sprite_mem [hcmm_pkg::SPRITE_BYTES];
    logic [7:0] io_mem     [hcmm_pkg::IO_BYTES];
    logic [7:0] high_mem   [hcmm_pkg::HIGH_BYTES];

    logic [2:0]  op_reg;
    logic [15:0] addr_reg;
    logic [15:0] wdata_reg;
    logic [7:0]  low_reg;
    logic [15:0] rdata_reg;
    logic        act_reg;
    logic        boot_reg, boot_next;
    hcmm_pkg::dma_state_t dma_reg, dma_next;
    logic [15:0] src_reg, src_next;
    logic [7:0]  cnt_reg, cnt_next;

    region_t     region_reg;
    region_t     rsel;
    logic [7:0]  boot_rd_reg;
    logic [7:0]  rom_rd_reg;
    logic [7:0]  video_rd_reg;
    logic [7:0]  cram_rd_reg;
    logic [7:0]  wram_rd_reg;
    logic [7:0]  sprite_rd_reg;
    logic [7:0]  io_rd_reg;
    logic [7:0]  high_rd_reg;

    logic [15:0] ra, wa;
    logic [7:0]  rv, wv;
    logic        do_write, is_tick, is_xfer;
    logic [15:0] read_word;

    assign is_tick = (op_reg == hcmm_pkg::OP_DMA_TICK);
    assign is_xfer = is_tick && (dma_reg == hcmm_pkg::DMA_XFER);
    assign status.two_access = (op_reg == hcmm_pkg::OP_READ_WORD) ||
                               (op_reg == hcmm_pkg::OP_WRITE_WORD) || is_xfer;

    // read address: second byte of a word wraps, dma reads source + count
    always_comb
    begin
        if (is_tick)
            ra = src_reg + {8'd0, cnt_reg};
        else if (cmd.second)
            ra = addr_reg + 16'd1;
        else
            ra = addr_reg;
    end

    // region of the read address, overlay decided at access time
    always_comb
    begin
        if (ra[15] == 1'b0)
        begin
            if (ra < hcmm_pkg::BOOT_END && boot_reg)
                rsel = RG_BOOT;
            else
                rsel = RG_ROM;
        end
        else if (ra[15:13] == 3'b100)
            rsel = RG_VIDEO;
        else if (ra[15:13] == 3'b101)
            rsel = RG_CRAM;
        else if (ra < hcmm_pkg::SPRITE_BASE)
            rsel = RG_WRAM;
        else if (ra < hcmm_pkg::GAP_BASE)
            rsel = RG_SPRITE;
        else if (ra < hcmm_pkg::IO_BASE)
            rsel = RG_GAP;
        else if (ra < hcmm_pkg::HIGH_BASE)
            rsel = RG_IO;
        else
            rsel = RG_HIGH;
    end

    // byte of the previous access, from the registered memory outputs
    always_comb
    begin
        unique case (region_reg)
            RG_BOOT:   rv = boot_rd_reg;
            RG_ROM:    rv = rom_rd_reg;
            RG_VIDEO:  rv = video_rd_reg;
            RG_CRAM:   rv = cram_rd_reg;
            RG_WRAM:   rv = wram_rd_reg;
            RG_SPRITE: rv = sprite_rd_reg;
            RG_IO:     rv = io_rd_reg;
            RG_HIGH:   rv = high_rd_reg;
            default:   rv = 8'd0;
        endcase
    end

    // write address and data per operation
    always_comb
    begin
        wa       = addr_reg;
        wv       = wdata_reg[7:0];
        do_write = 1'b0;
        unique case (op_reg)
            hcmm_pkg::OP_WRITE_BYTE:
            begin
                do_write = cmd.access;
            end
            hcmm_pkg::OP_WRITE_WORD:
            begin
                do_write = cmd.access;
                if (cmd.second)
                begin
                    wa = addr_reg + 16'd1;
                    wv = wdata_reg[15:8];
                end
            end
            hcmm_pkg::OP_DMA_TICK:
            begin
                // dma reads in the first access, writes that byte in the second
                do_write = cmd.access && cmd.second && (dma_reg == hcmm_pkg::DMA_XFER);
                wa       = hcmm_pkg::SPRITE_BASE + {8'd0, cnt_reg};
                wv       = rv;
            end
            default:
            begin
                do_write = 1'b0;
            end
        endcase
    end

    // control side effects of writes and ticks
    always_comb
    begin
        boot_next = boot_reg;
        dma_next  = dma_reg;
        src_next  = src_reg;
        cnt_next  = cnt_reg;
        if (do_write && wa >= hcmm_pkg::IO_BASE && wa < hcmm_pkg::HIGH_BASE)
        begin
            if (wa == hcmm_pkg::BOOT_OFF_ADDR && wv != 8'd0)
                boot_next = 1'b0;
            if (wa == hcmm_pkg::DMA_REG_ADDR)
            begin
                dma_next = hcmm_pkg::DMA_REQ;
                src_next = {wv, 8'd0};
            end
        end
        if (is_tick && cmd.finish)
        begin
            if (dma_reg == hcmm_pkg::DMA_REQ)
            begin
                cnt_next = 8'd0;
                dma_next = hcmm_pkg::DMA_XFER;
            end
            else if (dma_reg == hcmm_pkg::DMA_XFER)
            begin
                cnt_next = cnt_reg + 8'd1;
                // the copy returns to idle once the count reaches DMA_LENGTH
                if (!(dma_next == hcmm_pkg::DMA_REQ) &&
                    cnt_next >= 8'(DMA_LENGTH))
                    dma_next = hcmm_pkg::DMA_IDLE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && opcode == hcmm_pkg::OP_ROM_LOAD)
            rom_mem[address[RA-1:0]] <= write_data[7:0];
        if (do_write)
        begin
            if (wa[15:13] == 3'b100)
                video_mem[wa[VA-1:0]] <= wv;
            else if (wa[15:13] == 3'b101)
                cram_mem[wa[CA-1:0]] <= wv;
            else if (wa[15:14] == 2'b11 && wa < hcmm_pkg::SPRITE_BASE)
                wram_mem[wa[WA-1:0]] <= wv;
            else if (wa >= hcmm_pkg::SPRITE_BASE && wa < hcmm_pkg::GAP_BASE)
                sprite_mem[wa[SA-1:0]] <= wv;
            else if (wa >= hcmm_pkg::IO_BASE && wa < hcmm_pkg::HIGH_BASE)
                io_mem[wa[IA-1:0]] <= wv;
            else if (wa >= hcmm_pkg::HIGH_BASE)
                high_mem[wa[HA-1:0]] <= wv;
        end
        if (cmd.access)
        begin
            region_reg    <= rsel;
            boot_rd_reg   <= hcmm_pkg::boot_byte(ra[7:0]);
            rom_rd_reg    <= rom_mem[ra[RA-1:0]];
            video_rd_reg  <= video_mem[ra[VA-1:0]];
            cram_rd_reg   <= cram_mem[ra[CA-1:0]];
            wram_rd_reg   <= wram_mem[ra[WA-1:0]];
            sprite_rd_reg <= sprite_mem[ra[SA-1:0]];
            io_rd_reg     <= io_mem[ra[IA-1:0]];
            high_rd_reg   <= high_mem[ra[HA-1:0]];
        end
    end

    assign read_word = (op_reg == hcmm_pkg::OP_READ_WORD) ? {rv, low_reg} : {8'd0, rv};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            addr_reg  <= address;
            wdata_reg <= write_data;
        end
        // first byte arrives while the second is being read
        if (cmd.second)
            low_reg <= rv;
        if (cmd.finish)
        begin
            if (op_reg == hcmm_pkg::OP_READ_BYTE || op_reg == hcmm_pkg::OP_READ_WORD)
                rdata_reg <= read_word;
            else
                rdata_reg <= 16'd0;
            act_reg <= (dma_next == hcmm_pkg::DMA_REQ) || (dma_next == hcmm_pkg::DMA_XFER);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_reg <= 1'b1;
            dma_reg  <= hcmm_pkg::DMA_IDLE;
            src_reg  <= 16'd0;
            cnt_reg  <= 8'd0;
        end
        else
        begin
            boot_reg <= boot_next;
            dma_reg  <= dma_next;
            src_reg  <= src_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign read_data  = rdata_reg;
    assign dma_active = act_reg;

endmodule

@@ src/handheld_console_memory_map_with_dma.sv @@
// ----------------------------------------------------------------------------
// handheld_console_memory_map_with_dma
// console memory bus with boot overlay and sprite-table dma copy
// ----------------------------------------------------------------------------
// usage:
//   req carries opcode, address and write_data; rsp carries read_data and
//   dma_active, one response beat per request beat, in order.
//   a request beat is taken into the input registers, then the sequencer
//   performs each byte access in turn and a final state collects the
//   registered read data: byte reads, byte writes, rom loads and idle or
//   starting dma ticks use one access, word reads, word writes and copying
//   dma ticks two. the result is registered when that final state ends; a
//   new request is taken only when the sequencer is back in idle, so one
//   item's accesses are through before the next request is taken.
//   the response sits in an output register; a new request may be taken
//   while it waits, but that item holds before its result until the waiting
//   beat is taken, and no further request is taken meanwhile.
//   reset clears the sequencer, sets the boot overlay visible and idles the
//   dma engine; memory contents are undefined until written.
// ----------------------------------------------------------------------------
module handheld_console_memory_map_with_dma #(
    parameter int DMA_LENGTH = hcmm_pkg::DMA_LENGTH
) (
    input logic clk,
    input logic rst_n,
    hcmm_bus_if.sink   req,
    hcmm_bus_if.source rsp
);

    hcmm_pkg::dp_cmd_t    cmd;
    hcmm_pkg::dp_status_t status;

    hcmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    hcmm_datapath #(
        .DMA_LENGTH (DMA_LENGTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .opcode     (req.payload.opcode),
        .address    (req.payload.address),
        .write_data (req.payload.write_data),
        .read_data  (rsp.payload.read_data),
        .dma_active (rsp.payload.dma_active)
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the console memory bus: a shadow model of the map,
// the boot overlay and the sprite dma predicts every response beat; random
// request gaps and response stalls exercise the valid/ready handshakes
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] address;
        logic [15:0] write_data;
    } bus_req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        dma_active;
    } bus_rsp_t;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1100;

    logic clk;
    logic rst_n;

    hcmm_bus_if #(.payload_t(bus_req_t)) req_ch ();
    hcmm_bus_if #(.payload_t(bus_rsp_t)) rsp_ch ();

    handheld_console_memory_map_with_dma u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // shadow memory map
    logic [7:0] rom_mem [hcmm_pkg::ROM_BYTES];
    logic [7:0] vram_mem [hcmm_pkg::VIDEO_BYTES];
    logic [7:0] cram_mem [hcmm_pkg::CART_RAM_BYTES];
    logic [7:0] wram_mem [hcmm_pkg::WORK_RAM_BYTES];
    logic [7:0] oam_mem [hcmm_pkg::SPRITE_BYTES];
    logic [7:0] io_mem [hcmm_pkg::IO_BYTES];
    logic [7:0] hram_mem [hcmm_pkg::HIGH_BYTES];
    bit rom_wr [hcmm_pkg::ROM_BYTES];
    bit vram_wr [hcmm_pkg::VIDEO_BYTES];
    bit cram_wr [hcmm_pkg::CART_RAM_BYTES];
    bit wram_wr [hcmm_pkg::WORK_RAM_BYTES];
    bit oam_wr [hcmm_pkg::SPRITE_BYTES];
    bit io_wr [hcmm_pkg::IO_BYTES];
    bit hram_wr [hcmm_pkg::HIGH_BYTES];
    bit         boot_on;
    hcmm_pkg::dma_state_t copy_state;
    logic [15:0] copy_src;
    logic [7:0]  copy_idx;

    bus_req_t pending_q[$];
    bus_rsp_t expected_q[$];
    int       n_items;
    int       n_errors;
    bit       gen_done;

    function automatic logic [7:0] map_read(logic [15:0] a);
        if (!a[15])
            return (a < hcmm_pkg::BOOT_END && boot_on) ? hcmm_pkg::boot_byte(a[7:0])
                                                       : rom_mem[a[14:0]];
        if (a[15:13] == 3'b100) return vram_mem[a[12:0]];
        if (a[15:13] == 3'b101) return cram_mem[a[12:0]];
        if (a < hcmm_pkg::SPRITE_BASE) return wram_mem[a[12:0]];
        if (a < hcmm_pkg::GAP_BASE) return oam_mem[8'(a - hcmm_pkg::SPRITE_BASE)];
        if (a < hcmm_pkg::IO_BASE) return 8'h00;
        if (a < hcmm_pkg::HIGH_BASE) return io_mem[a[6:0]];
        return hram_mem[a[6:0]];
    endfunction

    function automatic bit map_readable(logic [15:0] a);
        if (!a[15]) return (a < hcmm_pkg::BOOT_END && boot_on) || rom_wr[a[14:0]];
        if (a[15:13] == 3'b100) return vram_wr[a[12:0]];
        if (a[15:13] == 3'b101) return cram_wr[a[12:0]];
        if (a < hcmm_pkg::SPRITE_BASE) return wram_wr[a[12:0]];
        if (a < hcmm_pkg::GAP_BASE) return oam_wr[8'(a - hcmm_pkg::SPRITE_BASE)];
        if (a < hcmm_pkg::IO_BASE) return 1'b1;
        if (a < hcmm_pkg::HIGH_BASE) return io_wr[a[6:0]];
        return hram_wr[a[6:0]];
    endfunction

    function automatic void map_write(logic [15:0] a, logic [7:0] v);
        if (!a[15]) return;
        if (a[15:13] == 3'b100)
        begin
            vram_mem[a[12:0]] = v;
            vram_wr[a[12:0]] = 1'b1;
        end
        else if (a[15:13] == 3'b101)
        begin
            cram_mem[a[12:0]] = v;
            cram_wr[a[12:0]] = 1'b1;
        end
        else if (a < hcmm_pkg::SPRITE_BASE)
        begin
            wram_mem[a[12:0]] = v;
            wram_wr[a[12:0]] = 1'b1;
        end
        else if (a < hcmm_pkg::GAP_BASE)
        begin
            oam_mem[8'(a - hcmm_pkg::SPRITE_BASE)] = v;
            oam_wr[8'(a - hcmm_pkg::SPRITE_BASE)] = 1'b1;
        end
        else if (a < hcmm_pkg::IO_BASE)
            return;
        else if (a < hcmm_pkg::HIGH_BASE)
        begin
            if (a == hcmm_pkg::BOOT_OFF_ADDR && v != 8'h00) boot_on = 1'b0;
            if (a == hcmm_pkg::DMA_REG_ADDR)
            begin
                copy_state = hcmm_pkg::DMA_REQ;
                copy_src = {v, 8'h00};
            end
            io_mem[a[6:0]] = v;
            io_wr[a[6:0]] = 1'b1;
        end
        else
        begin
            hram_mem[a[6:0]] = v;
            hram_wr[a[6:0]] = 1'b1;
        end
    endfunction

    function automatic void copy_tick();
        if (copy_state == hcmm_pkg::DMA_REQ)
        begin
            copy_idx = 8'd0;
            copy_state = hcmm_pkg::DMA_XFER;
        end
        else if (copy_state == hcmm_pkg::DMA_XFER)
        begin
            map_write(hcmm_pkg::SPRITE_BASE + 16'(copy_idx),
                      map_read(copy_src + 16'(copy_idx)));
            copy_idx = copy_idx + 8'd1;
            if (copy_idx >= hcmm_pkg::DMA_LENGTH) copy_state = hcmm_pkg::DMA_IDLE;
        end
    endfunction

    function automatic bus_rsp_t bus_predict(bus_req_t r);
        bus_rsp_t o;
        o.read_data = 16'h0000;
        case (r.opcode)
            hcmm_pkg::OP_READ_BYTE: o.read_data = {8'h00, map_read(r.address)};
            hcmm_pkg::OP_WRITE_BYTE: map_write(r.address, r.write_data[7:0]);
            hcmm_pkg::OP_READ_WORD:
                o.read_data = {map_read(r.address + 16'd1), map_read(r.address)};
            hcmm_pkg::OP_WRITE_WORD:
            begin
                map_write(r.address, r.write_data[7:0]);
                map_write(r.address + 16'd1, r.write_data[15:8]);
            end
            hcmm_pkg::OP_DMA_TICK: copy_tick();
            hcmm_pkg::OP_ROM_LOAD:
            begin
                rom_mem[r.address[14:0]] = r.write_data[7:0];
                rom_wr[r.address[14:0]] = 1'b1;
            end
            default: ;
        endcase
        o.dma_active = (copy_state == hcmm_pkg::DMA_REQ || copy_state == hcmm_pkg::DMA_XFER);
        return o;
    endfunction

    function automatic bit page_safe(logic [7:0] p);
        for (int k = 0; k < hcmm_pkg::DMA_LENGTH; k++)
            if (!map_readable({p, 8'h00} + 16'(k))) return 1'b0;
        return 1'b1;
    endfunction

    // a beat may only clear the boot overlay while no copy runs, and may only
    // start a copy from a page that reads defined bytes throughout
    function automatic bit byte_write_ok(logic [15:0] a, logic [7:0] v);
        if (a == hcmm_pkg::BOOT_OFF_ADDR && v != 8'h00 && copy_state != hcmm_pkg::DMA_IDLE)
            return 1'b0;
        if (a == hcmm_pkg::DMA_REG_ADDR && !page_safe(v)) return 1'b0;
        return 1'b1;
    endfunction

    task automatic issue(logic [2:0] op, logic [15:0] a, logic [15:0] d);
        bus_req_t r;
        r.opcode = op;
        r.address = a;
        r.write_data = d;
        pending_q.push_back(r);
        expected_q.push_back(bus_predict(r));
        n_items++;
    endtask

    function automatic logic [15:0] pick_addr();
        logic [15:0] bases [14] = '{16'h0000, 16'h0100, 16'h7F00, 16'h8000, 16'h9F00,
            16'hA000, 16'hBF00, 16'hC000, 16'hDF00, 16'hE000, 16'hFD00, 16'hFE00,
            16'hFF00, 16'hFF80};
        if ($urandom_range(0, 99) < 12) return 16'($urandom);
        return bases[$urandom_range(0, 13)] + 16'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_page();
        logic [7:0] pages [10] = '{8'h00, 8'h01, 8'h80, 8'h9F, 8'hA0, 8'hBF, 8'hC0,
            8'hE0, 8'hFD, 8'hFE};
        logic [7:0] p;
        for (int t = 0; t < 12; t++)
        begin
            p = (t < 10) ? pages[$urandom_range(0, 9)] : 8'($urandom);
            if (page_safe(p)) return p;
        end
        return 8'h00;
    endfunction

    task automatic random_write(logic [15:0] a);
        logic [15:0] d;
        bit          word;
        d = 16'($urandom);
        word = 1'($urandom_range(0, 1));
        if (a == hcmm_pkg::DMA_REG_ADDR || (word && a + 16'd1 == hcmm_pkg::DMA_REG_ADDR))
        begin
            if (word && a != hcmm_pkg::DMA_REG_ADDR) d[15:8] = pick_page();
            else d[7:0] = pick_page();
        end
        if (word && byte_write_ok(a, d[7:0]) && byte_write_ok(a + 16'd1, d[15:8]))
            issue(hcmm_pkg::OP_WRITE_WORD, a, d);
        else if (byte_write_ok(a, d[7:0]))
            issue(hcmm_pkg::OP_WRITE_BYTE, a, d);
        else
            issue(hcmm_pkg::OP_ROM_LOAD, a, d);
    endtask

    task automatic random_single();
        int          w;
        logic [15:0] a;
        bit          found;
        w = $urandom_range(0, 99);
        found = 1'b0;
        if (w < 45)
        begin
            for (int t = 0; t < 16 && !found; t++)
            begin
                a = pick_addr();
                if (w < 25) found = map_readable(a);
                else found = map_readable(a) && map_readable(a + 16'd1);
            end
            if (found)
                issue(w < 25 ? hcmm_pkg::OP_READ_BYTE : hcmm_pkg::OP_READ_WORD, a,
                      16'($urandom));
            else random_write(a);
        end
        else if (w < 75)
        begin
            case ($urandom_range(0, 19))
                0: a = hcmm_pkg::DMA_REG_ADDR;
                1: a = hcmm_pkg::DMA_REG_ADDR - 16'd1;
                2: a = hcmm_pkg::BOOT_OFF_ADDR;
                3: a = hcmm_pkg::BOOT_OFF_ADDR - 16'd1;
                default: a = pick_addr();
            endcase
            random_write(a);
        end
        else if (w < 84) issue(hcmm_pkg::OP_DMA_TICK, 16'($urandom), 16'($urandom));
        else if (w < 96) issue(hcmm_pkg::OP_ROM_LOAD, pick_addr(), 16'($urandom));
        else issue(w[0] ? OP_SPARE_6 : OP_SPARE_7, 16'($urandom), 16'($urandom));
    endtask

    task automatic fill_page();
        logic [7:0]  pages [7] = '{8'h80, 8'h9F, 8'hA0, 8'hBF, 8'hC0, 8'hDF, 8'hFD};
        logic [15:0] base;
        if ($urandom_range(0, 2) == 0)
        begin
            base = {7'd0, 1'($urandom), 8'h00};
            for (int k = 0; k < hcmm_pkg::DMA_LENGTH; k++)
                issue(hcmm_pkg::OP_ROM_LOAD, base + 16'(k), 16'($urandom));
        end
        else
        begin
            base = {pages[$urandom_range(0, 6)], 8'h00};
            for (int k = 0; k < hcmm_pkg::DMA_LENGTH; k += 2)
                issue(hcmm_pkg::OP_WRITE_WORD, base + 16'(k), 16'($urandom));
        end
    endtask

    task automatic copy_sequence();
        int guard;
        guard = 0;
        issue(hcmm_pkg::OP_WRITE_BYTE, hcmm_pkg::DMA_REG_ADDR, {8'($urandom), pick_page()});
        while (copy_state != hcmm_pkg::DMA_IDLE && guard < 600)
        begin
            if ($urandom_range(0, 9) < 7)
                issue(hcmm_pkg::OP_DMA_TICK, 16'($urandom), 16'($urandom));
            else random_single();
            guard++;
        end
    endtask

    initial
    begin
        boot_on = 1'b1;
        copy_state = hcmm_pkg::DMA_IDLE;
        copy_src = 16'h0000;
        copy_idx = 8'd0;
        n_items = 0;
        n_errors = 0;
        gen_done = 1'b0;

        // directed: overlay edge, rom wrap, word wrap, echo, gap, spare codes
        issue(hcmm_pkg::OP_ROM_LOAD, 16'h0100, 16'hFFA5);
        issue(hcmm_pkg::OP_ROM_LOAD, 16'hFFFF, 16'h005A);
        issue(hcmm_pkg::OP_READ_WORD, 16'h00FF, 16'h0000);
        issue(hcmm_pkg::OP_READ_BYTE, 16'h0000, 16'hFFFF);
        issue(hcmm_pkg::OP_READ_BYTE, 16'h7FFF, 16'h0000);
        issue(hcmm_pkg::OP_WRITE_BYTE, 16'h0100, 16'h0011);
        issue(hcmm_pkg::OP_READ_BYTE, 16'h0100, 16'h0000);
        issue(hcmm_pkg::OP_WRITE_WORD, 16'hFFFF, 16'h1234);
        issue(hcmm_pkg::OP_READ_BYTE, 16'hFFFF, 16'h0000);
        issue(hcmm_pkg::OP_WRITE_WORD, 16'hC000, 16'hBEEF);
        issue(hcmm_pkg::OP_READ_WORD, 16'hE000, 16'h0000);
        issue(hcmm_pkg::OP_WRITE_BYTE, 16'hFDFF, 16'h00C3);
        issue(hcmm_pkg::OP_READ_BYTE, 16'hDDFF, 16'h0000);
        issue(hcmm_pkg::OP_WRITE_BYTE, 16'hFEA5, 16'h0077);
        issue(hcmm_pkg::OP_WRITE_BYTE, 16'hFF00, 16'h0042);
        issue(hcmm_pkg::OP_READ_WORD, 16'hFEFF, 16'h0000);
        issue(hcmm_pkg::OP_WRITE_BYTE, hcmm_pkg::BOOT_OFF_ADDR, 16'hFF00);
        issue(hcmm_pkg::OP_READ_BYTE, hcmm_pkg::BOOT_OFF_ADDR, 16'h0000);
        issue(OP_SPARE_6, 16'hFFFF, 16'hFFFF);
        issue(OP_SPARE_7, 16'h0000, 16'h0000);
        issue(hcmm_pkg::OP_DMA_TICK, 16'h0000, 16'h0000);
        issue(hcmm_pkg::OP_WRITE_BYTE, hcmm_pkg::DMA_REG_ADDR, 16'h0000);
        issue(hcmm_pkg::OP_DMA_TICK, 16'hFFFF, 16'hFFFF);
        issue(hcmm_pkg::OP_WRITE_BYTE, hcmm_pkg::DMA_REG_ADDR, 16'h0000);
        issue(hcmm_pkg::OP_DMA_TICK, 16'h0000, 16'h0000);

        while (n_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0, 1: fill_page();
                2, 3, 4: copy_sequence();
                5: if (copy_state == hcmm_pkg::DMA_IDLE)
                    issue(hcmm_pkg::OP_WRITE_BYTE, hcmm_pkg::BOOT_OFF_ADDR,
                          16'($urandom_range(1, 255)));
                default: random_single();
            endcase
        end
        gen_done = 1'b1;
    end

    // request driver
    int req_gap;
    int req_count;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.payload <= '0;
            req_gap <= 0;
            req_count <= 0;
        end
        else if (!(req_ch.valid && !req_ch.ready))
        begin
            if (req_gap > 0)
            begin
                req_gap <= req_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                req_ch.payload <= pending_q.pop_front();
                req_ch.valid <= 1'b1;
                req_count <= req_count + 1;
                req_gap <= (req_count[6:5] == 2'b01) ? 0 : $urandom_range(0, 19);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // response stall control
    int rsp_stall;
    int rsp_count;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall <= 0;
            rsp_count <= 0;
        end
        else if (rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_count <= rsp_count + 1;
            if (rsp_count[6:5] == 2'b10)
            begin
                rsp_stall <= 0;
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_stall <= $urandom_range(0, 19);
                rsp_ch.ready <= 1'b0;
            end
        end
        else if (rsp_stall > 0)
        begin
            rsp_stall <= rsp_stall - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    task automatic report(string what, logic [15:0] exp_v, logic [15:0] got_v);
        $display("mismatch at %0t: %s expected %h got %h", $realtime, what, exp_v, got_v);
        n_errors++;
    endtask

    // response monitor
    always @(posedge clk)
    begin
        bus_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_q.size() == 0)
                report("unexpected beat", 16'h0000, rsp_ch.payload.read_data);
            else
            begin
                want = expected_q.pop_front();
                if (rsp_ch.payload.read_data !== want.read_data)
                    report("read_data", want.read_data, rsp_ch.payload.read_data);
                if (rsp_ch.payload.dma_active !== want.dma_active)
                    report("dma_active", 16'(want.dma_active), 16'(rsp_ch.payload.dma_active));
            end
        end
    end

    // watchdog on handshake progress
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!gen_done || pending_q.size() > 0 || req_ch.valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/hcmm_pkg.sv
src/hcmm_bus_if.sv
src/hcmm_ctrl.sv
src/hcmm_datapath.sv
src/handheld_console_memory_map_with_dma.sv
test/tb.sv
